// File: hw/rtl/cbbc_pkg.sv
package cbbc_pkg;

    // Frame limits and derived counter widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field and accumulator widths
    localparam int DIM_W   = 11;
    localparam int LEVEL_W = 8;
    localparam int PT_W    = 32;
    localparam int CNT_W   = 21;
    localparam int CSUM_W  = 30;
    localparam int SUM_W   = 52;

    // Register reset values
    localparam logic [DIM_W-1:0]   RESET_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = 11'd480;
    localparam logic [LEVEL_W-1:0] RESET_BRIGHT = 8'd245;
    localparam logic [LEVEL_W-1:0] RESET_DARK   = 8'd10;

    // Colour codes
    localparam logic [1:0] COLOR_NONE  = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;
    localparam logic [1:0] COLOR_GREEN = 2'd2;
    localparam logic [1:0] COLOR_BLUE  = 2'd3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BRIGHT_MIN   = 2'd2,
        REG_DARK_MAX     = 2'd3
    } cfg_index_t;

    // Quantity handed to the shared divider
    typedef enum logic [2:0] {
        DIV_COL = 3'd0,
        DIV_ROW = 3'd1,
        DIV_X   = 3'd2,
        DIV_Y   = 3'd3,
        DIV_Z   = 3'd4
    } div_sel_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   blue;
        logic [LEVEL_W-1:0]   green;
        logic [LEVEL_W-1:0]   red;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
        logic                 point_valid;
    } pixel_t;

    typedef struct packed {
        logic                   report_new;
        logic [1:0]             color_code;
        logic [10:0]            min_col;
        logic [9:0]             max_col;
        logic [10:0]            min_row;
        logic [9:0]             max_row;
        logic [9:0]             centroid_col;
        logic [9:0]             centroid_row;
        logic signed [PT_W-1:0] mean_x;
        logic signed [PT_W-1:0] mean_y;
        logic signed [PT_W-1:0] mean_z;
        logic [CNT_W-1:0]       valid_count;
    } report_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_pixel;
        logic zero_count;
        logic div_done;
    } dp_status_t;

endpackage

// File: hw/rtl/cbbc_div.sv
module cbbc_div import cbbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] num,
    input  logic [CNT_W-1:0] den,
    output logic             done,
    output logic [SUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: hw/rtl/cbbc_datapath.sv
module cbbc_datapath import cbbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pixel_t           pixel,
    input  logic             cfg_write,
    input  cfg_index_t       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    output report_t          report
);

    // Configuration registers
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [LEVEL_W-1:0] bright_reg, dark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            bright_reg <= RESET_BRIGHT;
            dark_reg   <= RESET_DARK;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_BRIGHT_MIN:   bright_reg <= cfg_data[LEVEL_W-1:0];
                REG_DARK_MAX:     dark_reg   <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, oversize acts as the maximum
    logic [DIM_W-1:0] w_eff, h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // Raster position
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_col, last_pixel;

    assign last_col   = ((DIM_W'(col_reg) + DIM_W'(1)) >= w_eff);
    assign last_pixel = last_col && ((DIM_W'(row_reg) + DIM_W'(1)) >= h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_pixel)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (last_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Colour box tests, index 0 red, 1 green, 2 blue
    logic [2:0] match;

    assign match[0] = (pixel.red >= bright_reg) && (pixel.green <= dark_reg)
                      && (pixel.blue <= dark_reg);
    assign match[1] = (pixel.green >= bright_reg) && (pixel.red <= dark_reg)
                      && (pixel.blue <= dark_reg);
    assign match[2] = (pixel.blue >= bright_reg) && (pixel.red <= dark_reg)
                      && (pixel.green <= dark_reg);

    // Per-colour accumulators
    logic [2:0]                    hit_reg, hit_next;
    logic [COL_W-1:0]              bminc_reg [3], bminc_next [3];
    logic [COL_W-1:0]              bmaxc_reg [3], bmaxc_next [3];
    logic [ROW_W-1:0]              bminr_reg [3], bminr_next [3];
    logic [ROW_W-1:0]              bmaxr_reg [3], bmaxr_next [3];
    logic [CNT_W-1:0]              cnt_reg [3], cnt_next [3];
    logic [CSUM_W-1:0]             csum_reg [3], csum_next [3];
    logic [CSUM_W-1:0]             rsum_reg [3], rsum_next [3];
    logic signed [SUM_W-1:0]       sx_reg [3], sx_next [3];
    logic signed [SUM_W-1:0]       sy_reg [3], sy_next [3];
    logic signed [SUM_W-1:0]       sz_reg [3], sz_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit_next[k]   = hit_reg[k];
            bminc_next[k] = bminc_reg[k];
            bmaxc_next[k] = bmaxc_reg[k];
            bminr_next[k] = bminr_reg[k];
            bmaxr_next[k] = bmaxr_reg[k];
            cnt_next[k]   = cnt_reg[k];
            csum_next[k]  = csum_reg[k];
            rsum_next[k]  = rsum_reg[k];
            sx_next[k]    = sx_reg[k];
            sy_next[k]    = sy_reg[k];
            sz_next[k]    = sz_reg[k];
            if (match[k])
            begin
                hit_next[k] = 1'b1;
                if (!hit_reg[k])
                begin
                    bminc_next[k] = col_reg;
                    bmaxc_next[k] = col_reg;
                    bminr_next[k] = row_reg;
                    bmaxr_next[k] = row_reg;
                end
                else
                begin
                    if (col_reg < bminc_reg[k]) bminc_next[k] = col_reg;
                    if (col_reg > bmaxc_reg[k]) bmaxc_next[k] = col_reg;
                    if (row_reg < bminr_reg[k]) bminr_next[k] = row_reg;
                    if (row_reg > bmaxr_reg[k]) bmaxr_next[k] = row_reg;
                end
                if (pixel.point_valid)
                begin
                    cnt_next[k]  = cnt_reg[k] + CNT_W'(1);
                    csum_next[k] = csum_reg[k] + CSUM_W'(col_reg);
                    rsum_next[k] = rsum_reg[k] + CSUM_W'(row_reg);
                    sx_next[k]   = sx_reg[k] + SUM_W'(pixel.point_x);
                    sy_next[k]   = sy_reg[k] + SUM_W'(pixel.point_y);
                    sz_next[k]   = sz_reg[k] + SUM_W'(pixel.point_z);
                end
            end
        end
    end

    // Hit flags and counts are control; a new frame clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k]  <= '0;
                csum_reg[k] <= '0;
                rsum_reg[k] <= '0;
                sx_reg[k]   <= '0;
                sy_reg[k]   <= '0;
                sz_reg[k]   <= '0;
            end
        end
        else if (cmd.accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (last_pixel)
                begin
                    hit_reg[k]  <= 1'b0;
                    cnt_reg[k]  <= '0;
                    csum_reg[k] <= '0;
                    rsum_reg[k] <= '0;
                    sx_reg[k]   <= '0;
                    sy_reg[k]   <= '0;
                    sz_reg[k]   <= '0;
                end
                else
                begin
                    hit_reg[k]  <= hit_next[k];
                    cnt_reg[k]  <= cnt_next[k];
                    csum_reg[k] <= csum_next[k];
                    rsum_reg[k] <= rsum_next[k];
                    sx_reg[k]   <= sx_next[k];
                    sy_reg[k]   <= sy_next[k];
                    sz_reg[k]   <= sz_next[k];
                end
            end
        end
    end

    // Box edges are only read once the hit flag is set
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                bminc_reg[k] <= bminc_next[k];
                bmaxc_reg[k] <= bmaxc_next[k];
                bminr_reg[k] <= bminr_next[k];
                bmaxr_reg[k] <= bmaxr_next[k];
            end
        end
    end

    // Frame end: pick first colour hit, red before green before blue
    logic       any_hit;
    logic [1:0] pick;
    logic [1:0] pick_code;

    always_comb
    begin
        any_hit   = |hit_next;
        pick      = 2'd0;
        pick_code = COLOR_NONE;
        if (hit_next[0])
        begin
            pick      = 2'd0;
            pick_code = COLOR_RED;
        end
        else if (hit_next[1])
        begin
            pick      = 2'd1;
            pick_code = COLOR_GREEN;
        end
        else if (hit_next[2])
        begin
            pick      = 2'd2;
            pick_code = COLOR_BLUE;
        end
    end

    // Snapshot of the chosen colour, and the result register
    logic                    reported_reg;
    report_t                 res_reg;
    logic [CSUM_W-1:0]       snap_csum_reg, snap_rsum_reg;
    logic signed [SUM_W-1:0] snap_sx_reg, snap_sy_reg, snap_sz_reg;
    logic                    neg_reg;
    logic signed [SUM_W-1:0] div_num;
    logic                    div_neg;
    logic [SUM_W-1:0]        div_mag;
    logic [SUM_W-1:0]        quot;
    logic [SUM_W-1:0]        quot_signed;
    logic                    div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
        end
        else if (cmd.accept && last_pixel)
        begin
            reported_reg <= any_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_pixel)
        begin
            res_reg <= '0;
            snap_csum_reg <= csum_next[pick];
            snap_rsum_reg <= rsum_next[pick];
            snap_sx_reg   <= sx_next[pick];
            snap_sy_reg   <= sy_next[pick];
            snap_sz_reg   <= sz_next[pick];
            if (any_hit)
            begin
                res_reg.report_new  <= !reported_reg;
                res_reg.color_code  <= pick_code;
                res_reg.min_col     <= 11'(bminc_next[pick]);
                res_reg.max_col     <= 10'(bmaxc_next[pick]);
                res_reg.min_row     <= 11'(bminr_next[pick]);
                res_reg.max_row     <= 10'(bmaxr_next[pick]);
                res_reg.valid_count <= cnt_next[pick];
            end
            else
            begin
                res_reg.valid_count <= '0;
            end
        end
        else if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                DIV_COL: res_reg.centroid_col <= quot_signed[9:0];
                DIV_ROW: res_reg.centroid_row <= quot_signed[9:0];
                DIV_X:   res_reg.mean_x       <= quot_signed[PT_W-1:0];
                DIV_Y:   res_reg.mean_y       <= quot_signed[PT_W-1:0];
                DIV_Z:   res_reg.mean_z       <= quot_signed[PT_W-1:0];
                default: ;
            endcase
        end
        if (cmd.div_start)
        begin
            neg_reg <= div_neg;
        end
    end

    // Dividend selection and sign handling around the unsigned divider
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_COL: div_num = SUM_W'(snap_csum_reg);
            DIV_ROW: div_num = SUM_W'(snap_rsum_reg);
            DIV_X:   div_num = snap_sx_reg;
            DIV_Y:   div_num = snap_sy_reg;
            DIV_Z:   div_num = snap_sz_reg;
            default: div_num = '0;
        endcase
        div_neg = div_num[SUM_W-1];
        div_mag = div_neg ? SUM_W'(-div_num) : SUM_W'(div_num);
    end

    assign quot_signed = neg_reg ? (~quot + SUM_W'(1)) : quot;

    cbbc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_mag),
        .den   (res_reg.valid_count),
        .done  (div_done),
        .quot  (quot)
    );

    assign status.last_pixel = last_pixel;
    assign status.zero_count = (res_reg.valid_count == '0);
    assign status.div_done   = div_done;
    assign report            = res_reg;

endmodule

// File: hw/rtl/cbbc_ctrl.sv
module cbbc_ctrl import cbbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_ACCUM,
        S_CHECK,
        S_START,
        S_RUN,
        S_REPORT
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;

    assign in_ready      = (state_reg == S_ACCUM);
    assign out_valid     = (state_reg == S_REPORT);
    assign cmd.accept    = in_valid && (state_reg == S_ACCUM);
    assign cmd.div_start = (state_reg == S_START);
    assign cmd.div_sel   = sel_reg;
    assign cmd.div_store = (state_reg == S_RUN) && status.div_done;

    // Frame end walks the five quotients through the shared divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            sel_reg   <= DIV_COL;
        end
        else
        begin
            unique case (state_reg)
                S_ACCUM:
                begin
                    if (in_valid && status.last_pixel)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    sel_reg <= DIV_COL;
                    if (status.zero_count)
                        state_reg <= S_REPORT;
                    else
                        state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (status.div_done)
                    begin
                        if (sel_reg == DIV_Z)
                        begin
                            state_reg <= S_REPORT;
                        end
                        else
                        begin
                            sel_reg   <= div_sel_t'(sel_reg + 3'd1);
                            state_reg <= S_START;
                        end
                    end
                end
                S_REPORT:
                begin
                    if (out_ready)
                        state_reg <= S_ACCUM;
                end
                default:
                begin
                    state_reg <= S_ACCUM;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/color_blob_bbox_centroid_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_data (pixel_t), one pixel per transfer
// out      output     out_valid/out_ready  out_data (report_t), one per frame
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data; always ready
//
// Pixels are taken one per cycle while a frame accumulates.
// At the last pixel of a frame the input stalls through a check state, then
// a start and a run state per quotient (start, bit steps, done) while one shared
// bit-serial divider forms the two centroids and three means (none when the
// valid count is zero), and stays stalled while the report waits for out_ready.
// Reset clears the raster position, per-colour flags, counts and sums.
module color_blob_bbox_centroid_unit import cbbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pixel_t           in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output report_t          out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cbbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cbbc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (in_data),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .report    (out_data)
    );

endmodule

// File: bench/color_blob_bbox_centroid_unit_tb.sv
`timescale 1ns / 100ps

module color_blob_bbox_centroid_unit_tb;
    import cbbc_pkg::*;

    // Expected frame reports, oldest first
    class blob_report_board;
        report_t pending_reports[$];
        int      fail_count;

        // Working copy of the block's settings and per-frame state
        logic [10:0] width_reg, height_reg;
        logic [7:0]  bright_reg, dark_reg;
        int unsigned col_pos, row_pos;
        bit          was_reported;
        bit          hit[3];
        int unsigned bmin_c[3], bmax_c[3], bmin_r[3], bmax_r[3];
        int unsigned npts[3];
        longint unsigned csum[3], rsum[3];
        longint      sx[3], sy[3], sz[3];

        function new();
            fail_count = 0;
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            bright_reg = RESET_BRIGHT;
            dark_reg = RESET_DARK;
            was_reported = 0;
            clear_frame();
        endfunction

        function int unsigned eff_size(logic [10:0] v, int unsigned top);
            int unsigned r;
            r = v;
            if (r == 0) r = 1;
            if (r > top) r = top;
            return r;
        endfunction

        function void clear_frame();
            for (int k = 0; k < 3; k++)
            begin
                hit[k] = 0;
                bmin_c[k] = eff_size(width_reg, MAX_WIDTH);
                bmin_r[k] = eff_size(height_reg, MAX_HEIGHT);
                bmax_c[k] = 0;
                bmax_r[k] = 0;
                npts[k] = 0;
                csum[k] = 0;
                rsum[k] = 0;
                sx[k] = 0;
                sy[k] = 0;
                sz[k] = 0;
            end
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [10:0] v);
            case (idx)
                REG_FRAME_WIDTH:  width_reg = v;
                REG_FRAME_HEIGHT: height_reg = v;
                REG_BRIGHT_MIN:   bright_reg = v[7:0];
                REG_DARK_MAX:     dark_reg = v[7:0];
            endcase
        endfunction

        function bit colour_match(logic [7:0] dom, logic [7:0] o1, logic [7:0] o2);
            return dom >= bright_reg && o1 <= dark_reg && o2 <= dark_reg;
        endfunction

        // Note an accepted pixel; queue a report at the frame end
        function void note_pixel(pixel_t p);
            bit m[3];
            int pick;
            int unsigned w, h;
            report_t rep;
            m[0] = colour_match(p.red, p.green, p.blue);
            m[1] = colour_match(p.green, p.red, p.blue);
            m[2] = colour_match(p.blue, p.red, p.green);
            for (int k = 0; k < 3; k++)
            begin
                if (m[k])
                begin
                    if (!hit[k])
                    begin
                        hit[k] = 1;
                        bmin_c[k] = col_pos; bmax_c[k] = col_pos;
                        bmin_r[k] = row_pos; bmax_r[k] = row_pos;
                    end
                    else
                    begin
                        if (col_pos < bmin_c[k]) bmin_c[k] = col_pos;
                        if (col_pos > bmax_c[k]) bmax_c[k] = col_pos;
                        if (row_pos < bmin_r[k]) bmin_r[k] = row_pos;
                        if (row_pos > bmax_r[k]) bmax_r[k] = row_pos;
                    end
                    if (p.point_valid)
                    begin
                        npts[k]++;
                        csum[k] += col_pos;
                        rsum[k] += row_pos;
                        sx[k] += longint'(p.point_x);
                        sy[k] += longint'(p.point_y);
                        sz[k] += longint'(p.point_z);
                    end
                end
            end
            w = eff_size(width_reg, MAX_WIDTH);
            h = eff_size(height_reg, MAX_HEIGHT);
            if (col_pos + 1 < w)
            begin
                col_pos++;
                return;
            end
            if (row_pos + 1 < h)
            begin
                col_pos = 0;
                row_pos++;
                return;
            end
            // Frame end: first colour hit wins
            rep = '0;
            pick = -1;
            for (int k = 2; k >= 0; k--)
                if (hit[k]) pick = k;
            if (pick < 0)
                was_reported = 0;
            else
            begin
                rep.report_new = !was_reported;
                was_reported = 1;
                rep.color_code = 2'(pick + 1);
                rep.min_col = 11'(bmin_c[pick]);
                rep.max_col = 10'(bmax_c[pick]);
                rep.min_row = 11'(bmin_r[pick]);
                rep.max_row = 10'(bmax_r[pick]);
                if (npts[pick] != 0)
                begin
                    rep.centroid_col = 10'(csum[pick] / npts[pick]);
                    rep.centroid_row = 10'(rsum[pick] / npts[pick]);
                    rep.mean_x = 32'(sx[pick] / longint'(npts[pick]));
                    rep.mean_y = 32'(sy[pick] / longint'(npts[pick]));
                    rep.mean_z = 32'(sz[pick] / longint'(npts[pick]));
                end
                rep.valid_count = 21'(npts[pick]);
            end
            pending_reports.push_back(rep);
            clear_frame();
        endfunction

        // Check one accepted report against the oldest expectation
        function void check_report(report_t got, realtime t);
            report_t exp_r;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report %p", t, got);
                fail_count++;
                return;
            end
            exp_r = pending_reports.pop_front();
            if (got.report_new !== exp_r.report_new)
                mismatch("report_new", t, exp_r.report_new, got.report_new);
            if (got.color_code !== exp_r.color_code)
                mismatch("color_code", t, exp_r.color_code, got.color_code);
            if (got.min_col !== exp_r.min_col)
                mismatch("min_col", t, exp_r.min_col, got.min_col);
            if (got.max_col !== exp_r.max_col)
                mismatch("max_col", t, exp_r.max_col, got.max_col);
            if (got.min_row !== exp_r.min_row)
                mismatch("min_row", t, exp_r.min_row, got.min_row);
            if (got.max_row !== exp_r.max_row)
                mismatch("max_row", t, exp_r.max_row, got.max_row);
            if (got.centroid_col !== exp_r.centroid_col)
                mismatch("centroid_col", t, exp_r.centroid_col, got.centroid_col);
            if (got.centroid_row !== exp_r.centroid_row)
                mismatch("centroid_row", t, exp_r.centroid_row, got.centroid_row);
            if (got.mean_x !== exp_r.mean_x)
                mismatch("mean_x", t, exp_r.mean_x, got.mean_x);
            if (got.mean_y !== exp_r.mean_y)
                mismatch("mean_y", t, exp_r.mean_y, got.mean_y);
            if (got.mean_z !== exp_r.mean_z)
                mismatch("mean_z", t, exp_r.mean_z, got.mean_z);
            if (got.valid_count !== exp_r.valid_count)
                mismatch("valid_count", t, exp_r.valid_count, got.valid_count);
        endfunction

        function void mismatch(string fld, realtime t, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s expected %h got %h", t, fld, e, a);
            fail_count++;
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    pixel_t     in_data = '0;
    logic       out_valid;
    logic       out_ready = 0;
    report_t    out_data;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_FRAME_WIDTH;
    logic [10:0] cfg_data = '0;

    blob_report_board board = new();
    bit  stim_done = 0;
    int  idle_cycles = 0;

    always #6 clk = ~clk;

    color_blob_bbox_centroid_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mostly short gaps, now and then a long one
    function int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Monitor: scoreboard on each transfer, watchdog on quiet cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_pixel(in_data);
            if (out_valid && out_ready)
                board.check_report(out_data, $realtime);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver with random stalls, some stretches fully ready
    initial
    begin
        int unsigned n;
        @(posedge clk);
        forever
        begin
            n = ($urandom_range(3) == 0) ? 0 : gap_len();
            out_ready <= 0;
            repeat (n) @(posedge clk);
            out_ready <= 1;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    end

    task automatic send_pixel(pixel_t p);
        int unsigned g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic stop_input();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [10:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Let every report drain, then the divider settle
    task automatic drain();
        stop_input();
        while (board.pending_reports.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [7:0] br,
                             logic [7:0] dk);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BRIGHT_MIN, {3'b0, br});
        write_reg(REG_DARK_MAX, {3'b0, dk});
    endtask

    // Pixel mostly matching one colour, or noise
    function pixel_t rand_pixel();
        pixel_t p;
        int unsigned kind;
        logic [7:0] br, dk;
        br = board.bright_reg;
        dk = board.dark_reg;
        p.point_x = $urandom;
        p.point_y = $urandom;
        p.point_z = $urandom;
        if ($urandom_range(3) == 0)
        begin
            p.point_x = $signed($urandom_range(200000)) - 100000;
            p.point_y = $signed($urandom_range(200000)) - 100000;
        end
        p.point_valid = $urandom_range(3) != 0;
        p.red = 8'($urandom_range(dk));
        p.green = 8'($urandom_range(dk));
        p.blue = 8'($urandom_range(dk));
        kind = $urandom_range(9);
        case (kind)
            0, 1:    p.red = 8'($urandom_range(255, br));
            2, 3:    p.green = 8'($urandom_range(255, br));
            4:       p.blue = 8'($urandom_range(255, br));
            5:
            begin
                p.red = 8'($urandom);
                p.green = 8'($urandom);
                p.blue = 8'($urandom);
            end
            default:
            begin
                p.red = 8'($urandom_range(255, dk));
                p.blue = 8'($urandom);
            end
        endcase
        return p;
    endfunction

    task automatic send_frames(int unsigned count);
        int unsigned npix;
        npix = board.eff_size(board.width_reg, MAX_WIDTH) *
               board.eff_size(board.height_reg, MAX_HEIGHT);
        repeat (count * npix) send_pixel(rand_pixel());
    endtask

    // Stimulus
    initial
    begin
        pixel_t p;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: 3x2 frames with boundary pixels and all colours
        set_frame(11'd3, 11'd2, 8'd245, 8'd10);
        p = '0; p.red = 8'd255; p.point_valid = 1;
        p.point_x = 32'sh7fffffff; p.point_y = 32'sh80000000; p.point_z = -1;
        send_pixel(p);
        p = '0; p.green = 8'd245; p.red = 8'd10; p.blue = 8'd10; p.point_valid = 1;
        send_pixel(p);
        p = '0; p.blue = 8'd255; p.red = 8'd255; send_pixel(p);
        p = '0; p.red = 8'd244; send_pixel(p);
        p = '0; p.red = 8'd250; p.green = 8'd11; send_pixel(p);
        p = '0; p.red = 8'd250; p.point_valid = 1;
        p.point_x = 32'sh7fffffff; p.point_y = 32'sh80000000; p.point_z = 32'sh80000000;
        send_pixel(p);
        // No colour, then green only with no valid point, then blue only
        p = '0; repeat (6) send_pixel(p);
        p = '0; p.green = 8'd255; send_pixel(p);
        p = '0; repeat (5) send_pixel(p);
        p = '0; p.blue = 8'd255; p.point_valid = 1; p.point_x = -7;
        repeat (6) send_pixel(p);

        // Width and height of zero act as one
        set_frame(11'd0, 11'd0, 8'd0, 8'd255);
        p = '1; send_pixel(p);
        p = '0; send_pixel(p);

        // Hold off until all reports are in
        drain();

        // Random frames across a range of settings
        set_frame(11'd8, 11'd6, 8'd245, 8'd10);
        send_frames(6);
        set_frame(11'd1, 11'd1, 8'd128, 8'd127);
        send_frames(40);
        set_frame(11'd2047, 11'd1, 8'd200, 8'd60);
        send_frames(1);
        set_frame(11'd5, 11'd4, 8'd230, 8'd30);
        send_frames(20);
        set_frame(11'd3, 11'd3, 8'd0, 8'd0);
        send_frames(10);

        drain();
        stim_done = 1;
        if (board.fail_count == 0 && board.pending_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cbbc_pkg.sv
hw/rtl/cbbc_div.sv
hw/rtl/cbbc_datapath.sv
hw/rtl/cbbc_ctrl.sv
hw/rtl/color_blob_bbox_centroid_unit.sv
bench/color_blob_bbox_centroid_unit_tb.sv
